### rtl/tkdp_pkg.sv
`default_nettype none
package tkdp_pkg;

  localparam int unsigned MaxItemsDef = 64;
  localparam int unsigned MaxDimDef   = 64;
  localparam int unsigned MaxKDef     = 8;

  localparam int unsigned ElemW   = 16;
  localparam int unsigned ScoreW  = 38;
  localparam int unsigned DimCfgW = 7;
  localparam int unsigned KCfgW   = 4;
  localparam int unsigned IdxOutW = 6;
  localparam int unsigned RkW     = 2;

  // Result kinds
  localparam logic [RkW-1:0] RkStoreAck = 2'd0;
  localparam logic [RkW-1:0] RkMatch    = 2'd1;
  localparam logic [RkW-1:0] RkEmpty    = 2'd2;

  // Configuration register indexes
  localparam logic RegDim  = 1'b0;
  localparam logic RegTopK = 1'b1;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic acc_en;
  } mac_ctrl_t;

endpackage
`default_nettype wire

### rtl/tkdp_mac.sv
`default_nettype none
// Shared multiply-accumulate: one product registered, then summed per cycle while accumulate is enabled
module tkdp_mac
  import tkdp_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire mac_ctrl_t                ctrl_i,
  input  wire logic signed [ElemW-1:0]  a_i,
  input  wire logic signed [ElemW-1:0]  b_i,
  output logic signed [ScoreW-1:0]      acc_o
);

  logic signed [2*ElemW-1:0] prod_q;
  logic signed [ScoreW-1:0]  acc_q;
  logic signed [ScoreW-1:0]  acc_d;

  // product stage, then wrapping accumulate
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.acc_en) begin
      acc_d = acc_q + ScoreW'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign acc_o = acc_q;

endmodule
`default_nettype wire

### rtl/top_k_dot_product_search.sv
`default_nettype none
// Brute-force top-k inner-product search. Elements are taken one per cycle
// while the block is idle. A completed store vector, or a query against an
// empty store, gives its one result through the acknowledge state, which
// registers it once any earlier result has been taken; input stalls until
// then. A completed query scans every stored vector through one shared
// 16x16 multiply-accumulate unit, one element per cycle. Each vector passes
// the dimension fetch, the element scan and the insert step, and, once the
// top-k table is full, the minimum search and the replace step. The
// exchange sort then orders the kept matches, emitted in turn, each waiting
// while the output stalls. Input stalls for the whole query. The vector
// store and query buffer hold undefined data after reset; a vector is read
// up to its own dimension, so a shorter query reads query buffer entries it
// did not write. Configuration is accepted only while the block is idle.
module top_k_dot_product_search
  import tkdp_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = MaxItemsDef,
  parameter int unsigned MAX_DIM   = MaxDimDef,
  parameter int unsigned MAX_K     = MaxKDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic                     kind_i,
  input  wire logic signed [ElemW-1:0]  element_i,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic                     cfg_index_i,
  input  wire logic [DimCfgW-1:0]       cfg_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [RkW-1:0]                result_kind_o,
  output logic                          status_o,
  output logic [IdxOutW-1:0]            item_index_o,
  output logic signed [ScoreW-1:0]      score_o,
  output logic                          last_o
);

  localparam int unsigned PW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned IW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned DW  = $clog2(MAX_DIM + 1);
  localparam int unsigned KW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int unsigned KCW = $clog2(MAX_K + 1);
  localparam int unsigned VD  = MAX_ITEMS * MAX_DIM;
  localparam int unsigned AW  = (VD > 1) ? $clog2(VD) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_ACK, S_DIM, S_SCAN, S_INSERT, S_MIN, S_NEXT, S_SORT, S_EMIT
  } state_e;

  state_e state_q;

  // configuration
  logic [DimCfgW-1:0] dim_cfg_q;
  logic [KCfgW-1:0]   k_cfg_q;
  logic [DW-1:0]      eff_dim;
  logic [KCW-1:0]     eff_k;

  always_comb begin
    if (dim_cfg_q == '0) eff_dim = DW'(1);
    else if (32'(dim_cfg_q) > MAX_DIM) eff_dim = DW'(MAX_DIM);
    else eff_dim = DW'(dim_cfg_q);
    if (k_cfg_q == '0) eff_k = KCW'(1);
    else if (32'(k_cfg_q) > MAX_K) eff_k = KCW'(MAX_K);
    else eff_k = KCW'(k_cfg_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_cfg_q <= DimCfgW'(64);
      k_cfg_q   <= KCfgW'(8);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegDim:  dim_cfg_q <= cfg_data_i;
        RegTopK: k_cfg_q   <= cfg_data_i[KCfgW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = (state_q == S_IDLE);

  // memories
  logic signed [ElemW-1:0] vmem [VD];
  logic [DW-1:0]           dmem [MAX_ITEMS];
  logic signed [ElemW-1:0] qbuf [MAX_DIM];
  logic signed [ElemW-1:0] vrd_q, qrd_q;
  logic [DW-1:0]           drd_q;

  logic [CW-1:0] stored_q;
  logic [PW-1:0] pos_q;
  logic          in_acc;
  logic          vec_done;
  logic          full;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (32'(stored_q) >= MAX_ITEMS);
  assign vec_done   = (DW'(pos_q) + DW'(1) >= eff_dim);

  // scan addressing
  logic [IW-1:0] sitem_q;
  logic [PW-1:0] sj_q;
  logic          rd_valid_q, rd_valid2_q;
  logic [AW-1:0] wr_addr, rd_addr;

  assign wr_addr = AW'(stored_q[IW-1:0]) * AW'(MAX_DIM) + AW'(pos_q);
  assign rd_addr = AW'(sitem_q) * AW'(MAX_DIM) + AW'(sj_q);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (kind_i) qbuf[pos_q] <= element_i;
      else if (!full) vmem[wr_addr] <= element_i;
      if (!kind_i && !full && vec_done) dmem[stored_q[IW-1:0]] <= eff_dim;
    end
    vrd_q <= vmem[rd_addr];
    qrd_q <= qbuf[sj_q];
    drd_q <= dmem[sitem_q];
  end

  // shared MAC unit
  mac_ctrl_t                mac_ctrl;
  logic signed [ScoreW-1:0] acc;
  tkdp_mac u_mac (
    .clk_i (clk_i), .rst_ni(rst_ni), .ctrl_i(mac_ctrl),
    .a_i(qrd_q), .b_i(vrd_q), .acc_o(acc)
  );

  // top-k table
  logic signed [ScoreW-1:0] bs_q [MAX_K];
  logic [IW-1:0]            bi_q [MAX_K];
  logic [KCW-1:0]           bcnt_q;
  logic [KW-1:0]            mi_q;
  logic [KCW-1:0]           mj_q;
  logic signed [ScoreW-1:0] cand_q;
  logic [IW-1:0]            cand_idx_q;
  logic [KCW-1:0]           si_q, sjj_q;
  logic [KCW-1:0]           ei_q;

  // pending single result of a store or an empty query
  logic [RkW-1:0]           ack_rk_q;
  logic                     ack_st_q;
  logic [IdxOutW-1:0]       ack_idx_q;

  logic [RkW-1:0]           o_rk_q;
  logic                     o_st_q, o_last_q, o_valid_q;
  logic [IdxOutW-1:0]       o_idx_q;
  logic signed [ScoreW-1:0] o_sc_q;

  // accumulator cleared while a vector's dimension is fetched; the second
  // read-pipeline stage carries the accumulate enable
  always_comb begin
    mac_ctrl.clear  = (state_q == S_DIM);
    mac_ctrl.acc_en = rd_valid2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stored_q    <= '0;
      pos_q       <= '0;
      o_valid_q   <= 1'b0;
      rd_valid_q  <= 1'b0;
      rd_valid2_q <= 1'b0;
      bcnt_q      <= '0;
      sitem_q     <= '0;
      sj_q        <= '0;
    end else begin
      rd_valid_q  <= (state_q == S_SCAN);
      rd_valid_q  <= (state_q == S_SCAN) ? 1'b1 : 1'b0;
      rd_valid2_q <= rd_valid_q;
      // a taken result drops out unless a new one is loaded below
      if (state_q != S_ACK && state_q != S_EMIT && !out_stall_i) o_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (!vec_done) begin
              pos_q <= pos_q + PW'(1);
            end else begin
              pos_q <= '0;
              if (kind_i) begin
                if (stored_q == '0) begin
                  ack_rk_q  <= RkEmpty;
                  ack_st_q  <= 1'b0;
                  ack_idx_q <= '0;
                  state_q   <= S_ACK;
                end else begin
                  sitem_q <= '0;
                  bcnt_q  <= '0;
                  state_q <= S_DIM;
                end
              end else begin
                ack_rk_q  <= RkStoreAck;
                ack_st_q  <= full;
                ack_idx_q <= full ? '0 : IdxOutW'(stored_q);
                if (!full) stored_q <= stored_q + CW'(1);
                state_q <= S_ACK;
              end
            end
          end
        end
        S_ACK: begin
          if (!o_valid_q || !out_stall_i) begin
            o_valid_q <= 1'b1;
            o_rk_q    <= ack_rk_q;
            o_st_q    <= ack_st_q;
            o_idx_q   <= ack_idx_q;
            o_sc_q    <= '0;
            o_last_q  <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        // dimension of sitem_q is read this cycle
        S_DIM: begin
          sj_q    <= '0;
          state_q <= S_SCAN;
        end
        // one element read per cycle
        S_SCAN: begin
          if (DW'(sj_q) + DW'(1) >= drd_q) begin
            sj_q    <= '0;
            state_q <= S_INSERT;
          end else begin
            sj_q <= sj_q + PW'(1);
          end
        end
        // wait for the last product to land, then fill or search the table
        S_INSERT: begin
          if (!rd_valid_q && !rd_valid2_q) begin
            cand_q     <= acc;
            cand_idx_q <= sitem_q;
            if (bcnt_q < eff_k) begin
              bs_q[bcnt_q[KW-1:0]] <= acc;
              bi_q[bcnt_q[KW-1:0]] <= sitem_q;
              bcnt_q  <= bcnt_q + KCW'(1);
              state_q <= S_NEXT;
            end else begin
              mi_q    <= '0;
              mj_q    <= KCW'(1);
              state_q <= S_MIN;
            end
          end
        end
        // first minimum, one compare per cycle, then replace if greater
        S_MIN: begin
          if (mj_q < eff_k) begin
            if (bs_q[mj_q[KW-1:0]] < bs_q[mi_q]) mi_q <= mj_q[KW-1:0];
            mj_q <= mj_q + KCW'(1);
          end else begin
            if (cand_q > bs_q[mi_q]) begin
              bs_q[mi_q] <= cand_q;
              bi_q[mi_q] <= cand_idx_q;
            end
            state_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (32'(sitem_q) + 32'd1 < 32'(stored_q)) begin
            sitem_q <= sitem_q + IW'(1);
            state_q <= S_DIM;
          end else begin
            si_q    <= '0;
            sjj_q   <= KCW'(1);
            state_q <= S_SORT;
          end
        end
        // exchange sort into descending order, one pair per cycle
        S_SORT: begin
          if (sjj_q < bcnt_q) begin
            if (bs_q[sjj_q[KW-1:0]] > bs_q[si_q[KW-1:0]]) begin
              bs_q[si_q[KW-1:0]]  <= bs_q[sjj_q[KW-1:0]];
              bs_q[sjj_q[KW-1:0]] <= bs_q[si_q[KW-1:0]];
              bi_q[si_q[KW-1:0]]  <= bi_q[sjj_q[KW-1:0]];
              bi_q[sjj_q[KW-1:0]] <= bi_q[si_q[KW-1:0]];
            end
            sjj_q <= sjj_q + KCW'(1);
          end else if (si_q + KCW'(1) < bcnt_q) begin
            si_q  <= si_q + KCW'(1);
            sjj_q <= si_q + KCW'(2);
          end else begin
            ei_q    <= '0;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!o_valid_q || !out_stall_i) begin
            o_valid_q <= 1'b1;
            o_rk_q    <= RkMatch;
            o_st_q    <= 1'b0;
            o_idx_q   <= IdxOutW'(bi_q[ei_q[KW-1:0]]);
            o_sc_q    <= bs_q[ei_q[KW-1:0]];
            o_last_q  <= (ei_q + KCW'(1) == bcnt_q);
            if (ei_q + KCW'(1) == bcnt_q) state_q <= S_IDLE;
            else ei_q <= ei_q + KCW'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = o_valid_q;
  assign result_kind_o = o_rk_q;
  assign status_o      = o_st_q;
  assign item_index_o  = o_idx_q;
  assign score_o       = o_sc_q;
  assign last_o        = o_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> state_q == S_IDLE) else $error("input taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcnt_q <= eff_k || state_q == S_IDLE || state_q == S_ACK)
    else $error("top-k overfilled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(score_o) && $stable(item_index_o)))
    else $error("stalled result changed");

endmodule
`default_nettype wire
